// ===== rtl/core/nppcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour match: shared package
// Widths, the palette contents and the record that moves along the cell chain.
// ----------------------------------------------------------------------------
package nppcm_pkg;

	// Field widths.
	localparam int PIX_W  = 8;
	localparam int IDX_W  = 4;
	localparam int FREQ_W = 14;

	// Number of palette entries in use (1 to 16); entries past fourteen are black.
	localparam int PALETTE_SIZE = 14;

	// Arithmetic widths of the redmean distance.
	localparam int RSUM_W = PIX_W + 1;      // sum of two red values
	localparam int SQ_W   = 2 * PIX_W;      // square of a channel difference
	localparam int WT_W   = 11;             // red or blue weight, 1024..1534
	localparam int PROD_W = WT_W + SQ_W;    // one weighted term
	localparam int DIST_W = PROD_W + 2;     // sum of three weighted terms

	localparam logic [WT_W-1:0] RED_WT_BASE  = WT_W'(1024);
	localparam logic [WT_W-1:0] BLUE_WT_BASE = WT_W'(1534);
	localparam int              GREEN_SHIFT  = 11;   // green weight is 2048

	// Larger than any real distance, so the first cell always takes its entry.
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// One palette entry.
	typedef struct packed {
		logic [PIX_W-1:0]  red;
		logic [PIX_W-1:0]  green;
		logic [PIX_W-1:0]  blue;
		logic [FREQ_W-1:0] freq;
	} entry_t;

	// Record handed from one cell to the next.
	typedef struct packed {
		logic              valid;
		logic [PIX_W-1:0]  red;
		logic [PIX_W-1:0]  green;
		logic [PIX_W-1:0]  blue;
		logic [DIST_W-1:0] best_dist;
		logic [IDX_W-1:0]  best_idx;
	} chain_t;

	// Fixed palette: colour and note frequency in hundredths of a hertz.
	function automatic entry_t palette_entry(input logic [IDX_W-1:0] idx);
		entry_t e;
		case (idx)
			4'd0:    e = '{8'd255, 8'd255, 8'd255, 14'd0};
			4'd1:    e = '{8'd0,   8'd0,   8'd0,   14'd0};
			4'd2:    e = '{8'd255, 8'd0,   8'd128, 14'd5500};
			4'd3:    e = '{8'd128, 8'd0,   8'd255, 14'd6174};
			4'd4:    e = '{8'd0,   8'd0,   8'd255, 14'd9250};
			4'd5:    e = '{8'd0,   8'd128, 8'd255, 14'd6930};
			4'd6:    e = '{8'd0,   8'd255, 8'd255, 14'd10383};
			4'd7:    e = '{8'd0,   8'd255, 8'd128, 14'd7778};
			4'd8:    e = '{8'd0,   8'd255, 8'd0,   14'd5827};
			4'd9:    e = '{8'd128, 8'd255, 8'd0,   14'd8731};
			4'd10:   e = '{8'd255, 8'd255, 8'd0,   14'd6541};
			4'd11:   e = '{8'd255, 8'd128, 8'd0,   14'd9800};
			4'd12:   e = '{8'd255, 8'd0,   8'd0,   14'd7342};
			4'd13:   e = '{8'd255, 8'd0,   8'd255, 14'd8241};
			default: e = '{8'd0,   8'd0,   8'd0,   14'd0};
		endcase
		return e;
	endfunction

	// Absolute difference of two channel values.
	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== rtl/core/nppcm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour match: one comparison cell
// Holds one palette entry, computes the redmean distance of the passing pixel
// over three stages and hands the pixel and the running best to the next cell.
// ----------------------------------------------------------------------------
module nppcm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  nppcm_pkg::entry_t             entry,
	input  logic [nppcm_pkg::IDX_W-1:0]   entry_idx,
	input  nppcm_pkg::chain_t             prev,
	output nppcm_pkg::chain_t             next
);
	import nppcm_pkg::*;

	logic              valid_s1, valid_s2, valid_s3;
	logic [PIX_W-1:0]  red_s1, green_s1, blue_s1;
	logic [PIX_W-1:0]  red_s2, green_s2, blue_s2;
	logic [PIX_W-1:0]  red_s3, green_s3, blue_s3;
	logic [DIST_W-1:0] best_dist_s1, best_dist_s2, best_dist_s3;
	logic [IDX_W-1:0]  best_idx_s1, best_idx_s2, best_idx_s3;
	logic [RSUM_W-1:0] rsum_s1;
	logic [SQ_W-1:0]   dr2_s1, dg2_s1, db2_s1;
	logic [PROD_W-1:0] wr_s2, wg_s2, wb_s2;

	logic [PIX_W-1:0]  dr, dg, db;
	logic [RSUM_W-1:0] rsum;
	logic [WT_W-1:0]   red_wt, blue_wt;
	logic [DIST_W-1:0] cand_dist;

	// Stage one: channel differences and their squares.
	assign dr   = abs_diff(prev.red, entry.red);
	assign dg   = abs_diff(prev.green, entry.green);
	assign db   = abs_diff(prev.blue, entry.blue);
	assign rsum = {1'b0, prev.red} + {1'b0, entry.red};

	// Stage two weights depend on the red sum.
	assign red_wt  = RED_WT_BASE + WT_W'(rsum_s1);
	assign blue_wt = BLUE_WT_BASE - WT_W'(rsum_s1);

	// Stage three: total distance.
	assign cand_dist = DIST_W'(wr_s2) + DIST_W'(wg_s2) + DIST_W'(wb_s2);

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= prev.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload of the three stages.
	always_ff @(posedge clk) begin
		if (en) begin
			red_s1       <= prev.red;
			green_s1     <= prev.green;
			blue_s1      <= prev.blue;
			best_dist_s1 <= prev.best_dist;
			best_idx_s1  <= prev.best_idx;
			rsum_s1      <= rsum;
			dr2_s1       <= SQ_W'({8'b0, dr} * {8'b0, dr});
			dg2_s1       <= SQ_W'({8'b0, dg} * {8'b0, dg});
			db2_s1       <= SQ_W'({8'b0, db} * {8'b0, db});

			red_s2       <= red_s1;
			green_s2     <= green_s1;
			blue_s2      <= blue_s1;
			best_dist_s2 <= best_dist_s1;
			best_idx_s2  <= best_idx_s1;
			wr_s2        <= PROD_W'({{SQ_W{1'b0}}, red_wt} * {{WT_W{1'b0}}, dr2_s1});
			wg_s2        <= PROD_W'(dg2_s1) << GREEN_SHIFT;
			wb_s2        <= PROD_W'({{SQ_W{1'b0}}, blue_wt} * {{WT_W{1'b0}}, db2_s1});

			red_s3       <= red_s2;
			green_s3     <= green_s2;
			blue_s3      <= blue_s2;
			// Strict less-than keeps the earlier entry on a tie.
			if (cand_dist < best_dist_s2) begin
				best_dist_s3 <= cand_dist;
				best_idx_s3  <= entry_idx;
			end else begin
				best_dist_s3 <= best_dist_s2;
				best_idx_s3  <= best_idx_s2;
			end
		end
	end

	assign next = '{valid_s3, red_s3, green_s3, blue_s3, best_dist_s3, best_idx_s3};

	// The running best never names an entry further down the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> best_idx_s3 <= entry_idx)
		else $error("cell best index beyond its own entry");

	// A held pipeline keeps its result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s3) && (!valid_s3 || $stable(best_idx_s3)))
		else $error("cell result changed while held");

	// The running best distance never grows along the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 |=> best_dist_s3 <= $past(best_dist_s2))
		else $error("cell best distance grew");

endmodule

// ===== rtl/core/nearest_palette_colour_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour match
// Finds the palette entry nearest to an RGB pixel under the redmean metric.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle while pixel_stall is low and returns,
// for each pixel in order, the index of the nearest palette entry (the lowest
// index on a tie) and that entry's note frequency in hundredths of a hertz.
// The pixel walks a row of PALETTE_SIZE cells, one per palette entry, each of
// three stages, followed by one output register. Every stage advances
// together: while a finished result waits with match_stall high, the whole
// chain holds and pixel_stall is raised.
// ----------------------------------------------------------------------------
module nearest_palette_colour_match (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_stall,
	input  logic [nppcm_pkg::PIX_W-1:0]    pixel_red,
	input  logic [nppcm_pkg::PIX_W-1:0]    pixel_green,
	input  logic [nppcm_pkg::PIX_W-1:0]    pixel_blue,
	output logic                           match_valid,
	input  logic                           match_stall,
	output logic [nppcm_pkg::IDX_W-1:0]    palette_index,
	output logic [nppcm_pkg::FREQ_W-1:0]   note_freq_centihz
);
	import nppcm_pkg::*;

	chain_t            chain [PALETTE_SIZE+1];
	logic              en;
	logic              match_valid_q;
	logic [IDX_W-1:0]  palette_index_q;
	logic [FREQ_W-1:0] note_freq_q;
	entry_t            winner;
	entry_t            shown;

	// The chain advances unless a result waits on a stalled output.
	assign en          = !match_valid_q || !match_stall;
	assign pixel_stall = !en;

	// Head of the chain: no entry seen yet.
	assign chain[0] = '{pixel_valid, pixel_red, pixel_green, pixel_blue, DIST_MAX,
		{IDX_W{1'b0}}};

	// One cell per palette entry.
	for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
		nppcm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.entry     (palette_entry(IDX_W'(i))),
			.entry_idx (IDX_W'(i)),
			.prev      (chain[i]),
			.next      (chain[i+1])
		);
	end

	assign winner = palette_entry(chain[PALETTE_SIZE].best_idx);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid_q <= 1'b0;
		end else if (en) begin
			match_valid_q <= chain[PALETTE_SIZE].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			palette_index_q <= chain[PALETTE_SIZE].best_idx;
			note_freq_q     <= winner.freq;
		end
	end

	assign match_valid       = match_valid_q;
	assign palette_index     = palette_index_q;
	assign note_freq_centihz = note_freq_q;

	// Palette entry named by the presented result.
	assign shown = palette_entry(palette_index);

	// The winning index is always a palette entry in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> palette_index <= IDX_W'(PALETTE_SIZE - 1))
		else $error("palette index out of range");

	// The frequency belongs to the entry that won.
	assert property (@(posedge clk) disable iff (!arst_n)
		match_valid |-> note_freq_centihz == shown.freq)
		else $error("frequency does not match the chosen entry");

	// A new result comes only from the last cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_valid) |-> $past(chain[PALETTE_SIZE].valid))
		else $error("result without a finished pixel");

endmodule
